// ----- rtl/core/szsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsm_pkg - stick zone servo mapper package
// Zone codes, servo width tables, register indexes and reset values shared
// by the mapper top level and its axis trackers.
// ----------------------------------------------------------------------------
package szsm_pkg;

  // Zone codes, bottom to top; NONE marks a reading sitting on a threshold
  typedef enum logic [2:0] {
    ZONE_BOTTOM = 3'd0,
    ZONE_LOW    = 3'd1,
    ZONE_CENTRE = 3'd2,
    ZONE_HIGH   = 3'd3,
    ZONE_TOP    = 3'd4,
    ZONE_NONE   = 3'd7
  } zone_t;

  // Command carried in the input word
  typedef enum logic {
    CMD_SAMPLE    = 1'b0,
    CMD_TRIM_TICK = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THR_VERY_HIGH = 3'd0,
    REG_THR_HIGH      = 3'd1,
    REG_THR_LOW       = 3'd2,
    REG_THR_VERY_LOW  = 3'd3,
    REG_MIN_WIDTH     = 3'd4,
    REG_MAX_WIDTH     = 3'd5,
    REG_TRIM_STEP     = 3'd6,
    REG_HOLD_SAMPLES  = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;
  localparam int unsigned WIDTH_BITS    = 12;
  localparam int unsigned TRIM_BITS     = 11;
  localparam int unsigned STEP_BITS     = 8;
  localparam int unsigned HOLD_BITS     = 8;

  // Register reset values
  localparam logic [11:0] THR_VERY_HIGH_RST = 12'd3808;
  localparam logic [11:0] THR_HIGH_RST      = 12'd2457;
  localparam logic [11:0] THR_LOW_RST       = 12'd1638;
  localparam logic [11:0] THR_VERY_LOW_RST  = 12'd41;
  localparam logic [11:0] MIN_WIDTH_RST     = 12'd1150;
  localparam logic [11:0] MAX_WIDTH_RST     = 12'd2350;
  localparam logic [7:0]  TRIM_STEP_RST     = 8'd32;
  localparam logic [7:0]  HOLD_SAMPLES_RST  = 8'd2;

  // Trim offset limits
  localparam logic signed [12:0] TRIM_MIN = -13'sd1024;
  localparam logic signed [12:0] TRIM_MAX = 13'sd1023;

  // The four zone thresholds
  typedef struct packed {
    logic [11:0] very_high;
    logic [11:0] high;
    logic [11:0] low;
    logic [11:0] very_low;
  } thresholds_t;

  // What an axis tracker reports for the word being accepted
  typedef struct packed {
    logic  take;   // run long enough: width takes the zone's value
    zone_t zone;   // zone of the current reading
  } axis_res_t;

  // Elevator pulse width per zone, microseconds
  function automatic logic [11:0] ele_zone_width(zone_t z);
    logic [11:0] w;
    case (z)
      ZONE_BOTTOM: w = 12'd1329;
      ZONE_LOW:    w = 12'd1437;
      ZONE_CENTRE: w = 12'd1545;
      ZONE_HIGH:   w = 12'd1771;
      ZONE_TOP:    w = 12'd1998;
      default:     w = 12'd1545;
    endcase
    return w;
  endfunction

  // Rudder pulse width per zone, microseconds
  function automatic logic [11:0] rud_zone_width(zone_t z);
    logic [11:0] w;
    case (z)
      ZONE_BOTTOM: w = 12'd2006;
      ZONE_LOW:    w = 12'd1868;
      ZONE_CENTRE: w = 12'd1730;
      ZONE_HIGH:   w = 12'd1544;
      ZONE_TOP:    w = 12'd1358;
      default:     w = 12'd1730;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/szsm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsm_in_if - input word channel
// Valid/ready channel carrying a stick sample or a trim tick.
// ----------------------------------------------------------------------------
interface szsm_in_if #(
  parameter int STICK_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [STICK_BITS-1:0] elevator_stick;
  logic [STICK_BITS-1:0] rudder_stick;
  logic                  trim_up_pressed;
  logic                  trim_down_pressed;

  modport source (
    output valid, cmd, elevator_stick, rudder_stick, trim_up_pressed, trim_down_pressed,
    input  ready
  );
  modport sink (
    input  valid, cmd, elevator_stick, rudder_stick, trim_up_pressed, trim_down_pressed,
    output ready
  );
endinterface

// ----- rtl/core/szsm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsm_out_if - result word channel
// Valid/ready channel carrying servo widths, trim offset and lamps.
// ----------------------------------------------------------------------------
interface szsm_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        elevator_width_us;
  logic [11:0]        rudder_width_us;
  logic signed [10:0] trim_offset_us;
  logic               up_lamp;
  logic               down_lamp;

  modport source (
    output valid, elevator_width_us, rudder_width_us, trim_offset_us, up_lamp, down_lamp,
    input  ready
  );
  modport sink (
    input  valid, elevator_width_us, rudder_width_us, trim_offset_us, up_lamp, down_lamp,
    output ready
  );
endinterface

// ----- rtl/core/szsm_axis_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsm_axis_track - one stick axis zone tracker
// Sorts a reading into a zone by strict threshold compares, keeps the held
// zone and its run count, and flags when the run exceeds the hold count.
// ----------------------------------------------------------------------------
module szsm_axis_track import szsm_pkg::*; #(
  parameter int STICK_BITS = 12,
  parameter int RUN_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [STICK_BITS-1:0] stick,
  input  thresholds_t           thr,
  input  logic [HOLD_BITS-1:0]  hold_samples,
  output axis_res_t             res
);

  localparam int CW = (STICK_BITS > 12) ? STICK_BITS : 12;
  localparam int RW = (RUN_BITS > HOLD_BITS) ? RUN_BITS : HOLD_BITS;

  zone_t               zone_r, zone_nxt, cur_zone;
  logic [RUN_BITS-1:0] run_r, run_nxt;
  logic [CW-1:0]       s, vh, hi, lo, vl;

  // classify the reading; a value on a threshold lands in no zone
  always_comb begin
    s  = CW'(stick);
    vh = CW'(thr.very_high);
    hi = CW'(thr.high);
    lo = CW'(thr.low);
    vl = CW'(thr.very_low);
    if (s > vh)                 cur_zone = ZONE_TOP;
    else if (s < vh && s > hi)  cur_zone = ZONE_HIGH;
    else if (s < hi && s > lo)  cur_zone = ZONE_CENTRE;
    else if (s < lo && s > vl)  cur_zone = ZONE_LOW;
    else if (s < vl)            cur_zone = ZONE_BOTTOM;
    else                        cur_zone = ZONE_NONE;
  end

  // run count: saturating repeat, restart at one on a new zone
  always_comb begin
    zone_nxt = zone_r;
    run_nxt  = run_r;
    if (cur_zone != ZONE_NONE) begin
      if (cur_zone == zone_r) begin
        if (run_r != {RUN_BITS{1'b1}}) run_nxt = run_r + 1'b1;
      end else begin
        zone_nxt = cur_zone;
        run_nxt  = RUN_BITS'(1);
      end
    end
    res.zone = cur_zone;
    res.take = (cur_zone != ZONE_NONE) && (RW'(run_nxt) > RW'(hold_samples));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_NONE;
      run_r  <= '0;
    end else if (en) begin
      zone_r <= zone_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

// ----- rtl/core/stick_zone_servo_mapper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_zone_servo_mapper_top - two-axis stick to servo width mapper
// Stick samples set elevator and rudder widths from held zones, with trim
// on the elevator and a min/max clamp; trim ticks move the trim and lamps.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    cmd, elevator/rudder stick, trim buttons
// out_ch    out  valid/ready    elevator/rudder width, trim offset, lamps
// cfg_*     in   write enable   register index, 12-bit data, no read-back
//
// One word per cycle: each word is finished in the cycle it is accepted and
// its result appears on out_ch the next cycle. The state registers are the
// result register; in_ch.ready is high while out_ch is empty or being taken,
// so a stalled result holds the state and throttles input. Reset is
// synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
module stick_zone_servo_mapper_top import szsm_pkg::*; #(
  parameter int STICK_BITS = 12,
  parameter int RUN_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  szsm_in_if.sink                  in_ch,
  szsm_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  thresholds_t           thr_r;
  logic [11:0]           min_width_r, max_width_r;
  logic [STEP_BITS-1:0]  trim_step_r;
  logic [HOLD_BITS-1:0]  hold_r;

  // mapper state, also the result word
  logic [11:0]           ele_width_r, ele_width_nxt;
  logic [11:0]           rud_width_r, rud_width_nxt;
  logic signed [10:0]    trim_r, trim_nxt;
  logic                  up_lamp_r, up_lamp_nxt;
  logic                  down_lamp_r, down_lamp_nxt;
  logic                  out_valid_r;

  logic                  accept, sample_en;
  axis_res_t             ele_res, rud_res;
  logic signed [13:0]    ele_raw, rud_raw;
  logic signed [12:0]    trim_a, trim_b, step_s;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sample_en   = accept && (cmd_t'(in_ch.cmd) == CMD_SAMPLE);

  // clamp: lower bound first, upper bound last
  function automatic logic [11:0] clamp_width(logic signed [13:0] w,
                                              logic [11:0] lo, logic [11:0] hi);
    logic signed [13:0] t;
    t = w;
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
    if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
    return t[11:0];
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.very_high <= THR_VERY_HIGH_RST;
      thr_r.high      <= THR_HIGH_RST;
      thr_r.low       <= THR_LOW_RST;
      thr_r.very_low  <= THR_VERY_LOW_RST;
      min_width_r     <= MIN_WIDTH_RST;
      max_width_r     <= MAX_WIDTH_RST;
      trim_step_r     <= TRIM_STEP_RST;
      hold_r          <= HOLD_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THR_VERY_HIGH: thr_r.very_high <= cfg_data;
        REG_THR_HIGH:      thr_r.high      <= cfg_data;
        REG_THR_LOW:       thr_r.low       <= cfg_data;
        REG_THR_VERY_LOW:  thr_r.very_low  <= cfg_data;
        REG_MIN_WIDTH:     min_width_r     <= cfg_data;
        REG_MAX_WIDTH:     max_width_r     <= cfg_data;
        REG_TRIM_STEP:     trim_step_r     <= cfg_data[STEP_BITS-1:0];
        REG_HOLD_SAMPLES:  hold_r          <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zone trackers, one per axis
  szsm_axis_track #(.STICK_BITS(STICK_BITS), .RUN_BITS(RUN_BITS)) u_ele_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (sample_en),
    .stick        (in_ch.elevator_stick),
    .thr          (thr_r),
    .hold_samples (hold_r),
    .res          (ele_res)
  );

  szsm_axis_track #(.STICK_BITS(STICK_BITS), .RUN_BITS(RUN_BITS)) u_rud_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (sample_en),
    .stick        (in_ch.rudder_stick),
    .thr          (thr_r),
    .hold_samples (hold_r),
    .res          (rud_res)
  );

  // widths: zone width (plus trim on elevator) or the held width, clamped
  always_comb begin
    if (ele_res.take)
      ele_raw = $signed({2'b00, ele_zone_width(ele_res.zone)}) + 14'(trim_r);
    else
      ele_raw = $signed({2'b00, ele_width_r});
    if (rud_res.take)
      rud_raw = $signed({2'b00, rud_zone_width(rud_res.zone)});
    else
      rud_raw = $signed({2'b00, rud_width_r});
  end

  // trim: up subtracts then down adds, each saturating
  always_comb begin
    step_s = $signed({5'b0, trim_step_r});
    trim_a = 13'(trim_r);
    if (in_ch.trim_up_pressed) begin
      trim_a = trim_a - step_s;
      if (trim_a < TRIM_MIN) trim_a = TRIM_MIN;
    end
    trim_b = trim_a;
    if (in_ch.trim_down_pressed) begin
      trim_b = trim_b + step_s;
      if (trim_b > TRIM_MAX) trim_b = TRIM_MAX;
    end
  end

  // next state per command
  always_comb begin
    ele_width_nxt = ele_width_r;
    rud_width_nxt = rud_width_r;
    trim_nxt      = trim_r;
    up_lamp_nxt   = up_lamp_r;
    down_lamp_nxt = down_lamp_r;
    case (cmd_t'(in_ch.cmd))
      CMD_SAMPLE: begin
        ele_width_nxt = clamp_width(ele_raw, min_width_r, max_width_r);
        rud_width_nxt = clamp_width(rud_raw, min_width_r, max_width_r);
      end
      CMD_TRIM_TICK: begin
        trim_nxt      = trim_b[10:0];
        up_lamp_nxt   = in_ch.trim_up_pressed;
        down_lamp_nxt = in_ch.trim_down_pressed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ele_width_r <= '0;
      rud_width_r <= '0;
      trim_r      <= '0;
      up_lamp_r   <= 1'b0;
      down_lamp_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ele_width_r <= ele_width_nxt;
        rud_width_r <= rud_width_nxt;
        trim_r      <= trim_nxt;
        up_lamp_r   <= up_lamp_nxt;
        down_lamp_r <= down_lamp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.elevator_width_us = ele_width_r;
  assign out_ch.rudder_width_us   = rud_width_r;
  assign out_ch.trim_offset_us    = trim_r;
  assign out_ch.up_lamp           = up_lamp_r;
  assign out_ch.down_lamp         = down_lamp_r;

  // every accepted word yields a result the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word gave no result");

  // a stick sample leaves trim and lamps alone
  a_sample_keeps_trim: assert property (@(posedge clk) disable iff (!rst_n)
    sample_en |=> ($stable(trim_r) && $stable(up_lamp_r) && $stable(down_lamp_r)))
    else $error("stick sample changed trim or lamps");

  // a trim tick leaves both widths alone
  a_tick_keeps_widths: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !sample_en) |=> ($stable(ele_width_r) && $stable(rud_width_r)))
    else $error("trim tick changed a servo width");

  // state only moves on an accepted word
  a_state_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(ele_width_r) && $stable(rud_width_r) && $stable(trim_r)))
    else $error("state moved without an accepted word");

endmodule

// ----- tb/sv/tb_stick_zone_servo_mapper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stick_zone_servo_mapper_top - self-checking bench for the servo mapper
// Drives stick samples and trim ticks through the input channel and keeps a
// behavioural copy of the mapper: zones, zone runs, widths, trim and lamps.
// Every result word is compared field by field with the oldest expected word.
// Directed words come first, then random traffic over several register
// settings, random idling on both channels and one long run with none.
// ----------------------------------------------------------------------------
module tb_stick_zone_servo_mapper_top;
  import szsm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TRIM_FLOOR   = -1024;
  localparam int TRIM_CEIL    = 1023;
  localparam int IDLE_PCT     = 31;

  // One input word as the sender sees it
  typedef struct {
    cmd_t        cmd;
    logic [11:0] ele;
    logic [11:0] rud;
    logic        up;
    logic        dn;
  } stick_word_t;

  // One result word
  typedef struct {
    logic [11:0]        elevator_width_us;
    logic [11:0]        rudder_width_us;
    logic signed [10:0] trim_offset_us;
    logic               up_lamp;
    logic               down_lamp;
  } servo_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  szsm_in_if #(.STICK_BITS(12)) in_ch ();
  szsm_out_if                   out_ch ();

  stick_zone_servo_mapper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register shadow, reset values
  logic [11:0] thr_very_high = 12'd3808;
  logic [11:0] thr_high      = 12'd2457;
  logic [11:0] thr_low       = 12'd1638;
  logic [11:0] thr_very_low  = 12'd41;
  logic [11:0] width_floor   = 12'd1150;
  logic [11:0] width_ceil    = 12'd2350;
  logic [7:0]  trim_step     = 8'd32;
  logic [7:0]  hold_count    = 8'd2;

  // Mapper state as predicted
  logic [11:0] ele_width     = '0;
  logic [11:0] rud_width     = '0;
  zone_t       ele_held      = ZONE_NONE;
  zone_t       rud_held      = ZONE_NONE;
  logic [7:0]  ele_run       = '0;
  logic [7:0]  rud_run       = '0;
  int          trim_us       = 0;
  logic        up_lamp_now   = 1'b0;
  logic        down_lamp_now = 1'b0;

  // Zone widths indexed bottom to top
  int ele_zone_us [5] = '{1329, 1437, 1545, 1771, 1998};
  int rud_zone_us [5] = '{2006, 1868, 1730, 1544, 1358};

  servo_word_t expected_servo_q [$];
  servo_word_t next_want;
  bit          gaps_on = 1'b1;
  int          words_sent = 0;
  int          words_checked = 0;
  int          mismatch_count = 0;
  int          settings_applied = 1;
  int          cycle_count = 0;

  // ---------------------------------------------------------------- prediction

  // Strict comparisons; a reading on a threshold lands in no zone
  function automatic zone_t zone_of(input logic [11:0] s);
    if (s > thr_very_high) return ZONE_TOP;
    if (s < thr_very_high && s > thr_high) return ZONE_HIGH;
    if (s < thr_high && s > thr_low) return ZONE_CENTRE;
    if (s < thr_low && s > thr_very_low) return ZONE_LOW;
    if (s < thr_very_low) return ZONE_BOTTOM;
    return ZONE_NONE;
  endfunction

  // Run counter saturates at 255; take once the run exceeds hold_count
  task automatic track_zone(input zone_t z, inout zone_t held, inout logic [7:0] run,
                            output bit take);
    take = 1'b0;
    if (z != ZONE_NONE) begin
      if (z == held) begin
        if (run != 8'hFF) run = run + 8'd1;
      end else begin
        held = z;
        run  = 8'd1;
      end
      take = (run > hold_count);
    end
  endtask

  // Floor first, ceiling last: floor above ceiling ends at the ceiling
  function automatic logic [11:0] clamp_width(input int w);
    int lo;
    int hi;
    lo = int'(width_floor);
    hi = int'(width_ceil);
    if (w < lo) w = lo;
    if (w > hi) w = hi;
    return w[11:0];
  endfunction

  task automatic map_stick_word(input stick_word_t w);
    int          ew;
    int          rw;
    int          step_i;
    bit          take_e;
    bit          take_r;
    zone_t       ze;
    zone_t       zr;
    servo_word_t want;
    if (w.cmd == CMD_SAMPLE) begin
      ew = int'(ele_width);
      rw = int'(rud_width);
      ze = zone_of(w.ele);
      zr = zone_of(w.rud);
      track_zone(ze, ele_held, ele_run, take_e);
      track_zone(zr, rud_held, rud_run, take_r);
      if (take_e) ew = ele_zone_us[ze] + trim_us;
      if (take_r) rw = rud_zone_us[zr];
      ele_width = clamp_width(ew);
      rud_width = clamp_width(rw);
    end else begin
      // up first, then down, each saturating
      step_i = int'(trim_step);
      if (w.up) begin
        trim_us = trim_us - step_i;
        if (trim_us < TRIM_FLOOR) trim_us = TRIM_FLOOR;
      end
      if (w.dn) begin
        trim_us = trim_us + step_i;
        if (trim_us > TRIM_CEIL) trim_us = TRIM_CEIL;
      end
      up_lamp_now   = w.up;
      down_lamp_now = w.dn;
    end
    want.elevator_width_us = ele_width;
    want.rudder_width_us   = rud_width;
    want.trim_offset_us    = trim_us[10:0];
    want.up_lamp           = up_lamp_now;
    want.down_lamp         = down_lamp_now;
    expected_servo_q.push_back(want);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic signed [12:0] want_v,
                             input logic signed [12:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result side: random stall, compare each word taken
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_servo_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_count++;
        end else begin
          next_want = expected_servo_q.pop_front();
          check_field("elevator_width_us", {1'b0, next_want.elevator_width_us},
                      {1'b0, out_ch.elevator_width_us});
          check_field("rudder_width_us", {1'b0, next_want.rudder_width_us},
                      {1'b0, out_ch.rudder_width_us});
          check_field("trim_offset_us", next_want.trim_offset_us, out_ch.trim_offset_us);
          check_field("up_lamp", {12'd0, next_want.up_lamp}, {12'd0, out_ch.up_lamp});
          check_field("down_lamp", {12'd0, next_want.down_lamp}, {12'd0, out_ch.down_lamp});
          words_checked++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_servo_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input cmd_t c, input logic [11:0] e, input logic [11:0] r,
                           input logic up, input logic dn);
    stick_word_t w;
    w.cmd = c;
    w.ele = e;
    w.rud = r;
    w.up  = up;
    w.dn  = dn;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.cmd               <= c;
    in_ch.elevator_stick    <= e;
    in_ch.rudder_stick      <= r;
    in_ch.trim_up_pressed   <= up;
    in_ch.trim_down_pressed <= dn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    map_stick_word(w);
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_servo_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_THR_VERY_HIGH: thr_very_high = value;
      REG_THR_HIGH:      thr_high      = value;
      REG_THR_LOW:       thr_low       = value;
      REG_THR_VERY_LOW:  thr_very_low  = value;
      REG_MIN_WIDTH:     width_floor   = value;
      REG_MAX_WIDTH:     width_ceil    = value;
      REG_TRIM_STEP:     trim_step     = value[7:0];
      REG_HOLD_SAMPLES:  hold_count    = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Full register set, only with the block idle
  task automatic apply_settings(input logic [11:0] vh, input logic [11:0] h,
                                input logic [11:0] l, input logic [11:0] vl,
                                input logic [11:0] lo, input logic [11:0] hi,
                                input logic [11:0] step, input logic [11:0] hold);
    drain_results();
    write_reg(REG_THR_VERY_HIGH, vh);
    write_reg(REG_THR_HIGH, h);
    write_reg(REG_THR_LOW, l);
    write_reg(REG_THR_VERY_LOW, vl);
    write_reg(REG_MIN_WIDTH, lo);
    write_reg(REG_MAX_WIDTH, hi);
    write_reg(REG_TRIM_STEP, step);
    write_reg(REG_HOLD_SAMPLES, hold);
    settings_applied++;
  endtask

  // Reading biased towards the thresholds and the ends of the range
  function automatic logic [11:0] pick_reading();
    logic [11:0] t;
    logic [11:0] v;
    int          sel;
    sel = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0:       t = thr_very_high;
      1:       t = thr_high;
      2:       t = thr_low;
      default: t = thr_very_low;
    endcase
    if (sel < 5)      v = 12'($urandom_range(0, 4095));
    else if (sel < 7) v = t;
    else if (sel < 9) v = ($urandom_range(0, 1) != 0) ? t + 12'd1 : t - 12'd1;
    else              v = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
    return v;
  endfunction

  // Held stick positions with jitter and trim ticks mixed in
  task automatic run_stick_traffic(input int n_words, input int up_pct, input int dn_pct);
    int          sent;
    int          seg;
    int          seg_max;
    logic [11:0] e;
    logic [11:0] r;
    logic [11:0] junk_e;
    logic [11:0] junk_r;
    sent = 0;
    while (sent < n_words) begin
      e       = pick_reading();
      r       = pick_reading();
      seg_max = (hold_count > 8) ? 12 : hold_count + 4;
      seg     = $urandom_range(1, seg_max);
      repeat (seg) begin
        junk_e = 12'($urandom_range(0, 4095));
        junk_r = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 99) < 15)
          send_word(CMD_TRIM_TICK, junk_e, junk_r, $urandom_range(0, 99) < up_pct,
                    $urandom_range(0, 99) < dn_pct);
        else if ($urandom_range(0, 99) < 10)
          send_word(CMD_SAMPLE, pick_reading(), r, junk_e[0], junk_r[0]);
        else if ($urandom_range(0, 99) < 5)
          send_word(CMD_SAMPLE, e, pick_reading(), junk_e[0], junk_r[0]);
        else
          send_word(CMD_SAMPLE, e, r, junk_e[0], junk_r[0]);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values: first-sample clamp, zones taking effect, threshold readings,
  // every trim button combination
  task automatic test_directed_defaults();
    repeat (3) send_word(CMD_SAMPLE, 12'h000, 12'hFFF, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 12'd3808, 12'd2457, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 12'd41, 12'd1638, 1'b0, 1'b1);
    repeat (3) send_word(CMD_SAMPLE, 12'd2000, 12'd3000, 1'b1, 1'b0);
    send_word(CMD_TRIM_TICK, 12'h000, 12'h000, 1'b1, 1'b0);
    send_word(CMD_TRIM_TICK, 12'hFFF, 12'hFFF, 1'b0, 1'b1);
    send_word(CMD_TRIM_TICK, 12'hAAA, 12'h555, 1'b1, 1'b1);
    send_word(CMD_TRIM_TICK, 12'h555, 12'hAAA, 1'b0, 1'b0);
    send_word(CMD_TRIM_TICK, 12'h000, 12'h000, 1'b1, 1'b0);
    repeat (3) send_word(CMD_SAMPLE, 12'd4000, 12'd100, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 12'd1000, 12'd40, 1'b0, 1'b0);
  endtask

  // All thresholds at zero, full width range, largest step, no hold
  task automatic test_low_extremes();
    apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd255, 12'd0);
    run_stick_traffic(160, 80, 15);
    run_stick_traffic(120, 10, 85);
  endtask

  // All thresholds at full scale, floor above ceiling, zero step, hold of 254
  task automatic test_high_extremes();
    apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0,
                   12'd254);
    run_stick_traffic(150, 50, 50);
  endtask

  // Random register sets, mostly ordered thresholds
  task automatic test_random_settings();
    logic [11:0] vl;
    logic [11:0] l;
    logic [11:0] h;
    logic [11:0] vh;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] step;
    logic [11:0] hold;
    for (int k = 0; k < 4; k++) begin
      if (k != 3) begin
        vl = 12'($urandom_range(0, 1000));
        l  = vl + 12'($urandom_range(1, 1000));
        h  = l + 12'($urandom_range(1, 1000));
        vh = h + 12'($urandom_range(1, 4095 - h));
      end else begin
        vl = 12'($urandom_range(0, 4095));
        l  = 12'($urandom_range(0, 4095));
        h  = 12'($urandom_range(0, 4095));
        vh = 12'($urandom_range(0, 4095));
      end
      lo = 12'($urandom_range(0, 2000));
      hi = 12'($urandom_range(1400, 4095));
      // upper data bits are driven too; the 8-bit registers drop them
      step = {4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))};
      hold = {4'($urandom_range(0, 15)), 8'($urandom_range(0, 4))};
      apply_settings(vh, h, l, vl, lo, hi, step, hold);
      run_stick_traffic(170, $urandom_range(10, 60), $urandom_range(10, 60));
    end
  endtask

  // Hold of 254 with the run counter saturating, no idling on either side,
  // and one pause for the results to catch up
  task automatic test_run_saturation();
    apply_settings(12'd3808, 12'd2457, 12'd1638, 12'd41, 12'd1150, 12'd2350, 12'd32,
                   12'd254);
    gaps_on = 1'b0;
    repeat (150) send_word(CMD_SAMPLE, 12'd2000, 12'd4000, 1'b0, 1'b0);
    drain_results();
    repeat (150) send_word(CMD_SAMPLE, 12'd2000, 12'd4000, 1'b1, 1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.cmd               <= CMD_SAMPLE;
    in_ch.elevator_stick    <= '0;
    in_ch.rudder_stick      <= '0;
    in_ch.trim_up_pressed   <= 1'b0;
    in_ch.trim_down_pressed <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_THR_VERY_HIGH;
    cfg_data                <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    test_run_saturation();

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d input words (samples and trim ticks) over %0d register sets,",
             words_sent, settings_applied);
    $display("including threshold readings, clamp extremes and trim saturation; %0d results.",
             words_checked);
    if (mismatch_count == 0 && expected_servo_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
